[hw/rtl/ahr_pkg.sv]
// Package for the auto hold relay controller.
// Holds the status and gear codes and the structs for configuration, tick beats and state.
// No dependencies.
package ahr_pkg;

    localparam logic [7:0] AH_OFF     = 8'h04;
    localparam logic [7:0] AH_READY   = 8'h20;
    localparam logic [7:0] AH_HOLDING = 8'h30;

    localparam logic [7:0] GEAR_PARK  = 8'h00;
    localparam logic [7:0] GEAR_DRIVE = 8'h05;
    localparam logic [7:0] GEAR_NEUT  = 8'h06;
    localparam logic [7:0] GEAR_REV   = 8'h07;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_RESUME_SPEED_LIMIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SPEED_MIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEUTRAL_CONFIRM_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_WAIT_TICKS   = 3'd3;

    localparam logic [7:0] RESET_RESUME_SPEED_LIMIT    = 8'd50;
    localparam logic [7:0] RESET_RELEASE_SPEED_MIN     = 8'd15;
    localparam logic [3:0] RESET_NEUTRAL_CONFIRM_TICKS = 4'd3;
    localparam logic [7:0] RESET_FEEDBACK_WAIT_TICKS   = 8'd30;

    localparam logic [3:0] NEUTRAL_COUNT_MAX = 4'd15;
    localparam logic [7:0] WAIT_COUNT_MAX    = 8'd255;
    localparam logic [7:0] PREV_HOLD_RESET   = 8'hFF;

    typedef struct packed {
        logic [7:0] resume_speed_limit;
        logic [7:0] release_speed_min;
        logic [3:0] neutral_confirm_ticks;
        logic [7:0] feedback_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] gear_code;
        logic [7:0] hold_status;
        logic [7:0] vehicle_speed;
        logic       cancel_event;
        logic       cruise_on;
        logic       brake_on;
        logic       data_stale;
    } tick_t;

    typedef struct packed {
        logic       first_pass;
        logic [7:0] prev_hold_status;
        logic       manual_off;
        logic       temp_pause;
        logic       reverse_seen;
        logic [3:0] neutral_count;
        logic [7:0] filtered_gear;
        logic       awaiting_feedback;
        logic [7:0] wait_count;
    } ctrl_state_t;

    localparam ctrl_state_t STATE_RESET = '{
        first_pass:        1'b1,
        prev_hold_status:  PREV_HOLD_RESET,
        manual_off:        1'b0,
        temp_pause:        1'b0,
        reverse_seen:      1'b0,
        neutral_count:     4'd0,
        filtered_gear:     GEAR_PARK,
        awaiting_feedback: 1'b0,
        wait_count:        8'd0
    };

endpackage

[hw/rtl/ahr_cfg_regs.sv]
// Configuration registers of the auto hold relay controller.
// Depends on ahr_pkg for the register indexes, reset values and cfg_t.
module ahr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [ahr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ahr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ahr_pkg::cfg_t                  cfg
);

    ahr_pkg::cfg_t cfg_reg;
    ahr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                ahr_pkg::REG_RESUME_SPEED_LIMIT:    cfg_next.resume_speed_limit = cfg_data;
                ahr_pkg::REG_RELEASE_SPEED_MIN:     cfg_next.release_speed_min = cfg_data;
                ahr_pkg::REG_NEUTRAL_CONFIRM_TICKS: cfg_next.neutral_confirm_ticks = cfg_data[3:0];
                ahr_pkg::REG_FEEDBACK_WAIT_TICKS:   cfg_next.feedback_wait_ticks = cfg_data;
                default:                            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resume_speed_limit    <= ahr_pkg::RESET_RESUME_SPEED_LIMIT;
            cfg_reg.release_speed_min     <= ahr_pkg::RESET_RELEASE_SPEED_MIN;
            cfg_reg.neutral_confirm_ticks <= ahr_pkg::RESET_NEUTRAL_CONFIRM_TICKS;
            cfg_reg.feedback_wait_ticks   <= ahr_pkg::RESET_FEEDBACK_WAIT_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ahr_decide.sv]
// Decision logic for one tick: next controller state, relay pulse and beep.
// Purely combinational; depends on ahr_pkg for codes and structs.
module ahr_decide (
    input  ahr_pkg::cfg_t        cfg,
    input  ahr_pkg::tick_t       tick,
    input  ahr_pkg::ctrl_state_t state_cur,
    output ahr_pkg::ctrl_state_t state_new,
    output logic                 relay_pulse,
    output logic                 beep_request
);

    always_comb
    begin
        ahr_pkg::ctrl_state_t st;
        logic                 fire;
        logic                 beep;
        logic                 waiting;
        logic [7:0]           ah;
        logic [7:0]           spd;

        st      = state_cur;
        fire    = 1'b0;
        beep    = 1'b0;
        waiting = 1'b0;
        ah      = tick.hold_status;
        spd     = tick.vehicle_speed;

        if (tick.data_stale)
        begin
            st.awaiting_feedback = 1'b0;
        end
        else
        begin
            if (st.first_pass)
            begin
                if (ah == ahr_pkg::AH_OFF)
                begin
                    st.manual_off = 1'b1;
                end
                st.prev_hold_status = ah;
                st.first_pass = 1'b0;
            end

            if (ah != st.prev_hold_status)
            begin
                if (!st.awaiting_feedback)
                begin
                    if (ah == ahr_pkg::AH_OFF)
                    begin
                        st.manual_off = 1'b1;
                        st.temp_pause = 1'b0;
                    end
                    else if (ah == ahr_pkg::AH_READY || ah == ahr_pkg::AH_HOLDING)
                    begin
                        st.manual_off = 1'b0;
                        st.temp_pause = 1'b0;
                    end
                end
                st.prev_hold_status = ah;
            end

            if (tick.gear_code == ahr_pkg::GEAR_NEUT)
            begin
                if (st.neutral_count < ahr_pkg::NEUTRAL_COUNT_MAX)
                begin
                    st.neutral_count = st.neutral_count + 4'd1;
                end
                if (st.neutral_count >= cfg.neutral_confirm_ticks)
                begin
                    st.filtered_gear = ahr_pkg::GEAR_NEUT;
                end
            end
            else
            begin
                st.filtered_gear = tick.gear_code;
                st.neutral_count = 4'd0;
            end

            if (st.awaiting_feedback)
            begin
                waiting = 1'b1;
                if (st.wait_count < ahr_pkg::WAIT_COUNT_MAX)
                begin
                    st.wait_count = st.wait_count + 8'd1;
                end
                if (st.wait_count >= cfg.feedback_wait_ticks)
                begin
                    st.awaiting_feedback = 1'b0;
                end
            end

            if (!waiting)
            begin
                if (tick.cancel_event && !tick.cruise_on && spd < cfg.resume_speed_limit
                    && !st.manual_off)
                begin
                    beep = 1'b1;
                    if (st.temp_pause)
                    begin
                        st.temp_pause = 1'b0;
                        if (ah == ahr_pkg::AH_OFF)
                        begin
                            fire = 1'b1;
                        end
                    end
                    else
                    begin
                        if (ah == ahr_pkg::AH_READY)
                        begin
                            if (tick.brake_on)
                            begin
                                fire = 1'b1;
                            end
                        end
                        else if (ah != ahr_pkg::AH_OFF)
                        begin
                            fire = 1'b1;
                        end
                        st.temp_pause = 1'b1;
                        st.reverse_seen = 1'b0;
                    end
                end

                if (st.temp_pause && spd >= cfg.resume_speed_limit)
                begin
                    st.temp_pause = 1'b0;
                    if (ah == ahr_pkg::AH_OFF)
                    begin
                        fire = 1'b1;
                    end
                end

                if (st.filtered_gear == ahr_pkg::GEAR_REV)
                begin
                    st.reverse_seen = 1'b1;
                    if (!st.temp_pause && !st.manual_off && !fire)
                    begin
                        if (ah == ahr_pkg::AH_HOLDING
                            || (ah == ahr_pkg::AH_READY && tick.brake_on))
                        begin
                            fire = 1'b1;
                        end
                    end
                end

                if (!fire && st.filtered_gear == ahr_pkg::GEAR_DRIVE
                    && spd >= cfg.release_speed_min && st.reverse_seen)
                begin
                    if (!st.manual_off && ah == ahr_pkg::AH_OFF)
                    begin
                        fire = 1'b1;
                        st.temp_pause = 1'b0;
                    end
                    st.reverse_seen = 1'b0;
                end

                if (!fire && st.filtered_gear == ahr_pkg::GEAR_DRIVE && spd == 8'd0
                    && ah == ahr_pkg::AH_OFF)
                begin
                    if (!st.temp_pause && !st.manual_off && !st.reverse_seen)
                    begin
                        fire = 1'b1;
                    end
                end

                if (st.filtered_gear == ahr_pkg::GEAR_PARK)
                begin
                    st.reverse_seen = 1'b0;
                    st.temp_pause = 1'b0;
                    if (!st.manual_off && !fire && ah == ahr_pkg::AH_OFF)
                    begin
                        fire = 1'b1;
                    end
                end

                if (fire)
                begin
                    st.awaiting_feedback = 1'b1;
                    st.wait_count = 8'd0;
                end
            end
        end

        state_new    = st;
        relay_pulse  = fire;
        beep_request = beep;
    end

endmodule

[hw/rtl/auto_hold_relay_controller.sv]
// Top level of the auto hold relay controller: tick input register, controller state,
// result register. Depends on ahr_pkg, ahr_cfg_regs and ahr_decide.
//
//  Channel   Handshake               Payload
//  tick in   in_valid / in_stall     gear_code, hold_status, vehicle_speed, cancel_event,
//                                    cruise_on, brake_on, data_stale
//  result    out_valid / out_stall   relay_pulse, beep_request
//  config    cfg_write_en            cfg_index, cfg_data
//
// One tick beat is taken per cycle while the input is not stalled; it is registered in the
// tick register, and its result in the result register. The decision is combinational
// between the two, and the controller state is updated in the same cycle as the result register.
// Reset restores all configuration registers and the controller state.
// A stalled result register holds the tick register, which then stalls the input.
module auto_hold_relay_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      gear_code,
    input  logic [7:0]                      hold_status,
    input  logic [7:0]                      vehicle_speed,
    input  logic                            cancel_event,
    input  logic                            cruise_on,
    input  logic                            brake_on,
    input  logic                            data_stale,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            relay_pulse,
    output logic                            beep_request,
    input  logic                            cfg_write_en,
    input  logic [ahr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ahr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ahr_pkg::cfg_t        cfg;
    ahr_pkg::tick_t       tick_reg;
    logic                 tick_valid_reg;
    ahr_pkg::ctrl_state_t state_reg;
    ahr_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 relay_reg;
    logic                 beep_reg;
    logic                 relay_next;
    logic                 beep_next;
    logic                 advance;
    logic                 take_in;

    ahr_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    ahr_decide u_decide (
        .cfg          (cfg),
        .tick         (tick_reg),
        .state_cur    (state_reg),
        .state_new    (state_next),
        .relay_pulse  (relay_next),
        .beep_request (beep_next)
    );

    assign advance  = tick_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = tick_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ahr_pkg::STATE_RESET;
        end
        else
        begin
            if (take_in)
            begin
                tick_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                tick_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            tick_reg.gear_code     <= gear_code;
            tick_reg.hold_status   <= hold_status;
            tick_reg.vehicle_speed <= vehicle_speed;
            tick_reg.cancel_event  <= cancel_event;
            tick_reg.cruise_on     <= cruise_on;
            tick_reg.brake_on      <= brake_on;
            tick_reg.data_stale    <= data_stale;
        end
        if (advance)
        begin
            relay_reg <= relay_next;
            beep_reg  <= beep_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign relay_pulse  = relay_reg;
    assign beep_request = beep_reg;

endmodule

[test/auto_hold_relay_controller_tb.sv]
// Testbench for auto_hold_relay_controller: directed and random control ticks, with the
// relay and beep decisions predicted tick by tick and checked beat by beat.
// Depends on ahr_pkg and the auto_hold_relay_controller RTL.
`timescale 1ns / 1ps

module auto_hold_relay_controller_tb;

    import ahr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 4;

    typedef struct {
        logic relay;
        logic beep;
    } relay_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             gear_code;
    logic [7:0]             hold_status;
    logic [7:0]             vehicle_speed;
    logic                   cancel_event;
    logic                   cruise_on;
    logic                   brake_on;
    logic                   data_stale;
    logic                   out_valid;
    logic                   out_stall;
    logic                   relay_pulse;
    logic                   beep_request;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    relay_expect_t relay_predictions[$];
    cfg_t          setup;
    ctrl_state_t   ctl;
    logic [7:0]    sticky_gear;
    logic [7:0]    sticky_hold;

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int errors           = 0;
    int cycle_count      = 0;
    int ticks_sent       = 0;
    int pulses_predicted = 0;
    int beeps_predicted  = 0;
    int settings_applied = 0;

    auto_hold_relay_controller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .gear_code    (gear_code),
        .hold_status  (hold_status),
        .vehicle_speed(vehicle_speed),
        .cancel_event (cancel_event),
        .cruise_on    (cruise_on),
        .brake_on     (brake_on),
        .data_stale   (data_stale),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .relay_pulse  (relay_pulse),
        .beep_request (beep_request),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, relay_predictions.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void predict_relay(input tick_t t, output logic pulse,
                                          output logic beep);
        logic fire;
        fire  = 1'b0;
        beep  = 1'b0;
        pulse = 1'b0;
        if (t.data_stale)
        begin
            ctl.awaiting_feedback = 1'b0;
            return;
        end
        if (ctl.first_pass)
        begin
            if (t.hold_status == AH_OFF)
                ctl.manual_off = 1'b1;
            ctl.prev_hold_status = t.hold_status;
            ctl.first_pass = 1'b0;
        end
        if (t.hold_status != ctl.prev_hold_status)
        begin
            if (t.hold_status == AH_OFF)
            begin
                if (!ctl.awaiting_feedback)
                begin
                    ctl.manual_off = 1'b1;
                    ctl.temp_pause = 1'b0;
                end
            end
            else if (t.hold_status == AH_READY || t.hold_status == AH_HOLDING)
            begin
                if (!ctl.awaiting_feedback)
                begin
                    ctl.manual_off = 1'b0;
                    ctl.temp_pause = 1'b0;
                end
            end
            ctl.prev_hold_status = t.hold_status;
        end
        if (t.gear_code == GEAR_NEUT)
        begin
            if (ctl.neutral_count < NEUTRAL_COUNT_MAX)
                ctl.neutral_count = ctl.neutral_count + 4'd1;
            if (ctl.neutral_count >= setup.neutral_confirm_ticks)
                ctl.filtered_gear = GEAR_NEUT;
        end
        else
        begin
            ctl.filtered_gear = t.gear_code;
            ctl.neutral_count = 4'd0;
        end
        if (ctl.awaiting_feedback)
        begin
            if (ctl.wait_count < WAIT_COUNT_MAX)
                ctl.wait_count = ctl.wait_count + 8'd1;
            if (ctl.wait_count >= setup.feedback_wait_ticks)
                ctl.awaiting_feedback = 1'b0;
            return;
        end
        if (t.cancel_event && !t.cruise_on && t.vehicle_speed < setup.resume_speed_limit
            && !ctl.manual_off)
        begin
            beep = 1'b1;
            if (ctl.temp_pause)
            begin
                ctl.temp_pause = 1'b0;
                if (t.hold_status == AH_OFF)
                    fire = 1'b1;
            end
            else
            begin
                if (t.hold_status == AH_READY)
                    fire = t.brake_on;
                else if (t.hold_status != AH_OFF)
                    fire = 1'b1;
                ctl.temp_pause = 1'b1;
                ctl.reverse_seen = 1'b0;
            end
        end
        if (ctl.temp_pause && t.vehicle_speed >= setup.resume_speed_limit)
        begin
            ctl.temp_pause = 1'b0;
            if (t.hold_status == AH_OFF)
                fire = 1'b1;
        end
        if (ctl.filtered_gear == GEAR_REV)
        begin
            ctl.reverse_seen = 1'b1;
            if (!ctl.temp_pause && !ctl.manual_off && !fire)
            begin
                if (t.hold_status == AH_HOLDING || (t.hold_status == AH_READY && t.brake_on))
                    fire = 1'b1;
            end
        end
        if (!fire && ctl.filtered_gear == GEAR_DRIVE
            && t.vehicle_speed >= setup.release_speed_min && ctl.reverse_seen)
        begin
            if (!ctl.manual_off && t.hold_status == AH_OFF)
            begin
                fire = 1'b1;
                ctl.temp_pause = 1'b0;
            end
            ctl.reverse_seen = 1'b0;
        end
        if (!fire && ctl.filtered_gear == GEAR_DRIVE && t.vehicle_speed == 8'd0
            && t.hold_status == AH_OFF)
        begin
            if (!ctl.temp_pause && !ctl.manual_off && !ctl.reverse_seen)
                fire = 1'b1;
        end
        if (ctl.filtered_gear == GEAR_PARK)
        begin
            ctl.reverse_seen = 1'b0;
            ctl.temp_pause = 1'b0;
            if (!ctl.manual_off && !fire && t.hold_status == AH_OFF)
                fire = 1'b1;
        end
        if (fire)
        begin
            ctl.awaiting_feedback = 1'b1;
            ctl.wait_count = 8'd0;
        end
        pulse = fire;
    endfunction

    function automatic tick_t make_tick(input logic [7:0] gear, hold, speed,
                                        input logic cancel, cruise, brake, stale);
        tick_t t;
        t.gear_code     = gear;
        t.hold_status   = hold;
        t.vehicle_speed = speed;
        t.cancel_event  = cancel;
        t.cruise_on     = cruise;
        t.brake_on      = brake;
        t.data_stale    = stale;
        return t;
    endfunction

    // Gear and hold status mostly persist across ticks so that neutral runs, reverse
    // manoeuvres and pauses develop; a small share of beats is pure noise.
    function automatic tick_t random_tick();
        tick_t t;
        int    spd;
        if ($urandom_range(99) < 8)
        begin
            t = tick_t'($urandom);
            t.data_stale = ($urandom_range(9) == 0);
            return t;
        end
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(5))
                0: sticky_gear = GEAR_PARK;
                1: sticky_gear = GEAR_DRIVE;
                2: sticky_gear = GEAR_NEUT;
                3: sticky_gear = GEAR_REV;
                4: sticky_gear = GEAR_DRIVE;
                default: sticky_gear = 8'($urandom_range(255));
            endcase
        end
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(7))
                0, 1: sticky_hold = AH_OFF;
                2, 3: sticky_hold = AH_READY;
                4, 5, 6: sticky_hold = AH_HOLDING;
                default: sticky_hold = 8'($urandom_range(255));
            endcase
        end
        case ($urandom_range(4))
            0: spd = 0;
            1: spd = int'(setup.resume_speed_limit) + int'($urandom_range(4)) - 2;
            2: spd = int'(setup.release_speed_min) + int'($urandom_range(4)) - 2;
            default: spd = int'($urandom_range(255));
        endcase
        if (spd < 0)
            spd = 0;
        if (spd > 255)
            spd = 255;
        t.gear_code     = sticky_gear;
        t.hold_status   = sticky_hold;
        t.vehicle_speed = 8'(spd);
        t.cancel_event  = ($urandom_range(99) < 25);
        t.cruise_on     = ($urandom_range(99) < 10);
        t.brake_on      = $urandom_range(1);
        t.data_stale    = ($urandom_range(99) < 4);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        logic pulse;
        logic beep;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        gear_code     <= t.gear_code;
        hold_status   <= t.hold_status;
        vehicle_speed <= t.vehicle_speed;
        cancel_event  <= t.cancel_event;
        cruise_on     <= t.cruise_on;
        brake_on      <= t.brake_on;
        data_stale    <= t.data_stale;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_relay(t, pulse, beep);
        relay_predictions.push_back('{relay: pulse, beep: beep});
        ticks_sent++;
        pulses_predicted += pulse;
        beeps_predicted += beep;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_tick(random_tick());
    endtask

    // Holds the input off until every predicted result has come back.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (relay_predictions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (index)
            REG_RESUME_SPEED_LIMIT:    setup.resume_speed_limit = data;
            REG_RELEASE_SPEED_MIN:     setup.release_speed_min = data;
            REG_NEUTRAL_CONFIRM_TICKS: setup.neutral_confirm_ticks = data[3:0];
            REG_FEEDBACK_WAIT_TICKS:   setup.feedback_wait_ticks = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] resume, release_min, neutral, fb_wait);
        settle_block();
        write_reg(REG_RESUME_SPEED_LIMIT, resume);
        write_reg(REG_RELEASE_SPEED_MIN, release_min);
        write_reg(REG_NEUTRAL_CONFIRM_TICKS, neutral);
        write_reg(REG_FEEDBACK_WAIT_TICKS, fb_wait);
        settings_applied++;
    endtask

    task automatic test_reset_defaults();
        send_tick(make_tick(GEAR_PARK, AH_READY, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_READY, 8'd49, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_cancel_paths();
        apply_setting(8'd50, 8'd15, 8'd3, 8'd1);
        send_tick(make_tick(GEAR_DRIVE, AH_HOLDING, 8'd10, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd10, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd10, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd10, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_READY, 8'd10, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_READY, 8'd10, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_READY, 8'd50, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_READY, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_gear_paths();
        send_tick(make_tick(GEAR_REV, AH_HOLDING, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_REV, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd15, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_DRIVE, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        repeat (4)
            send_tick(make_tick(GEAR_NEUT, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(GEAR_PARK, AH_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick(GEAR_PARK, AH_HOLDING, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_register_extremes();
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
        send_random(30);
        apply_setting(8'd255, 8'd255, 8'd15, 8'd255);
        send_random(30);
        apply_setting(8'd255, 8'd0, 8'd1, 8'd1);
        send_random(30);
        apply_setting(8'd0, 8'd255, 8'd15, 8'd2);
        send_random(30);
        // Writes to unused indexes must leave the live settings alone, and only the
        // low nibble of the neutral confirm count is kept.
        apply_setting(8'd100, 8'd30, 8'hF2, 8'd3);
        for (int i = REG_FEEDBACK_WAIT_TICKS + 1; i < 2 ** CFG_INDEX_W; i++)
            write_reg(CFG_INDEX_W'(i), 8'hFF);
        send_random(30);
    endtask

    task automatic test_idle_mix(input int snd_pct, input int rcv_pct);
        apply_setting(8'($urandom_range(20, 120)), 8'($urandom_range(1, 60)),
                      8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        send_random(130);
    endtask

    always @(posedge clk)
    begin : result_check
        relay_expect_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (relay_predictions.size() == 0)
            begin
                $display("%0t: result beat with none expected: relay_pulse %0b beep_request %0b",
                         $time, relay_pulse, beep_request);
                errors++;
            end
            else
            begin
                want = relay_predictions.pop_front();
                if (relay_pulse !== want.relay)
                begin
                    $display("%0t: relay_pulse expected %0b, got %0b",
                             $time, want.relay, relay_pulse);
                    errors++;
                end
                if (beep_request !== want.beep)
                begin
                    $display("%0t: beep_request expected %0b, got %0b",
                             $time, want.beep, beep_request);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        gear_code     = 8'd0;
        hold_status   = 8'd0;
        vehicle_speed = 8'd0;
        cancel_event  = 1'b0;
        cruise_on     = 1'b0;
        brake_on      = 1'b0;
        data_stale    = 1'b0;
        out_stall     = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = REG_RESUME_SPEED_LIMIT;
        cfg_data      = 8'd0;
        ctl           = STATE_RESET;
        setup.resume_speed_limit    = RESET_RESUME_SPEED_LIMIT;
        setup.release_speed_min     = RESET_RELEASE_SPEED_MIN;
        setup.neutral_confirm_ticks = RESET_NEUTRAL_CONFIRM_TICKS;
        setup.feedback_wait_ticks   = RESET_FEEDBACK_WAIT_TICKS;
        sticky_gear   = GEAR_PARK;
        sticky_hold   = AH_READY;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 83;
        test_reset_defaults();
        test_cancel_paths();
        test_gear_paths();
        test_register_extremes();
        test_idle_mix(37, 83);
        test_idle_mix(83, 37);
        test_idle_mix(0, 0);
        settle_block();

        $display("Sent %0d tick beats across %0d register settings and three idling mixes.",
                 ticks_sent, settings_applied);
        $display("Predicted %0d relay pulses and %0d beeps; %0d mismatches.",
                 pulses_predicted, beeps_predicted, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ahr_pkg.sv
hw/rtl/ahr_cfg_regs.sv
hw/rtl/ahr_decide.sv
hw/rtl/auto_hold_relay_controller.sv
test/auto_hold_relay_controller_tb.sv
